// ----- rtl/acsa_pkg.sv -----
// Package for the converter channel scan averager: constants, types, helpers.
// No dependencies.
`timescale 1ns / 1ps
package acsa_pkg;

  localparam int unsigned NumCh   = 4;
  localparam int unsigned ChW     = 2;
  localparam int unsigned AddrW   = 6;

  // request codes
  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_STATUS = 2'd1,
    REQ_READ   = 2'd2,
    REQ_START  = 2'd3
  } req_e;

  // result kinds
  typedef enum logic [1:0] {
    KIND_CMD  = 2'd0,
    KIND_RD   = 2'd1,
    KIND_MEAS = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  // register indexes
  typedef enum logic [2:0] {
    REG_MASK   = 3'd0,
    REG_MUX    = 3'd1,
    REG_GAIN   = 3'd2,
    REG_RATE   = 3'd3,
    REG_AVG    = 3'd4,
    REG_SCALE  = 3'd5,
    REG_OFFSET = 3'd6,
    REG_DEVADR = 3'd7
  } reg_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_e;

  // measurement unit request/answer
  typedef struct packed {
    logic               start;
    logic signed [23:0] sum;
    logic [2:0]         gain;
    logic signed [15:0] scale;
    logic signed [15:0] offset;
    logic [7:0]         count;
  } meas_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] value;
  } meas_rsp_t;

  localparam logic [15:0] CmdBase = 16'h8103;
  localparam logic [7:0]  WaitBase = 8'h88;

  // full scale in mV for a gain code
  function automatic logic [13:0] full_scale(input logic [2:0] g);
    logic [13:0] fs;
    fs = (g == 3'd0) ? 14'd6144 : 14'(14'h2000 >> g);
    return fs;
  endfunction

endpackage

// ----- rtl/acsa_if.sv -----
// Valid/ready channel interface carrying one beat of payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface acsa_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic              bus_error;
  logic signed [15:0] sample;
  modport source (output valid, req_type, bus_error, sample, input ready);
  modport sink (input valid, req_type, bus_error, sample, output ready);
endinterface

interface acsa_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [6:0]        bus_address;
  logic [15:0]       config_word;
  logic [1:0]        channel;
  logic signed [31:0] value;
  logic              last;
  modport source (output valid, kind, bus_address, config_word, channel, value, last,
                  input ready);
  modport sink (input valid, kind, bus_address, config_word, channel, value, last,
                output ready);
endinterface

// ----- rtl/acsa_meas.sv -----
// Measurement unit: multiplies sum by full scale and scale, then divides
// by count<<23 bit-serially with rounding, adds offset, saturates. Uses acsa_pkg.
`timescale 1ns / 1ps
module acsa_meas (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  acsa_pkg::meas_req_t  req_i,
  output acsa_pkg::meas_rsp_t  rsp_o
);

  acsa_pkg::state_e   state_q, state_d;
  logic [53:0]        mag_q, mag_d;     // |num| then quotient
  logic               neg_q, neg_d;
  logic [31:0]        rem_q, rem_d;     // remainder, den up to 2^31
  logic [5:0]         cnt_q, cnt_d;
  logic signed [15:0] scale_q, off_q;
  logic signed [15:0] req_scale_q;
  logic [7:0]         cnt8_q;
  logic signed [38:0] p1_q;
  logic signed [54:0] prod;
  logic [31:0]        den;
  logic [32:0]        trial;
  logic signed [55:0] res;

  // single multiplier, reused for both products
  always_comb begin
    prod = 55'(p1_q) * 55'(scale_q);
  end

  assign den = {1'b0, ((cnt8_q == 8'd0) ? 8'd1 : cnt8_q), 23'd0};
  assign trial = {rem_q, mag_q[53]};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      acsa_pkg::ST_IDLE: if (req_i.start) state_d = acsa_pkg::ST_MUL1;
      acsa_pkg::ST_MUL1: state_d = acsa_pkg::ST_MUL2;
      acsa_pkg::ST_MUL2: state_d = acsa_pkg::ST_DIV;
      acsa_pkg::ST_DIV:  if (cnt_q == 6'd53) state_d = acsa_pkg::ST_FIN;
      acsa_pkg::ST_FIN:  state_d = acsa_pkg::ST_OUT;
      acsa_pkg::ST_OUT:  state_d = acsa_pkg::ST_IDLE;
      default:           state_d = acsa_pkg::ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    mag_d = mag_q;
    neg_d = neg_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    unique case (state_q)
      acsa_pkg::ST_MUL2: begin
        neg_d = prod[54];
        mag_d = prod[54] ? 54'(-prod) : prod[53:0];
        rem_d = '0;
        cnt_d = '0;
      end
      acsa_pkg::ST_DIV: begin
        // one quotient bit per cycle
        if (trial >= {1'b0, den}) begin
          rem_d = 32'(trial - {1'b0, den});
          mag_d = {mag_q[52:0], 1'b1};
        end else begin
          rem_d = trial[31:0];
          mag_d = {mag_q[52:0], 1'b0};
        end
        cnt_d = cnt_q + 6'd1;
      end
      acsa_pkg::ST_FIN: begin
        // round half away: remainder >= den/2
        if ({1'b0, rem_q} >= {2'b0, den[31:1]}) mag_d = mag_q + 54'd1;
      end
      default: ;
    endcase
  end

  assign res = (neg_q ? -56'(mag_q) : 56'(mag_q)) + 56'(off_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= acsa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    neg_q <= neg_d;
    rem_q <= rem_d;
    cnt_q <= cnt_d;
    if (state_q == acsa_pkg::ST_IDLE && req_i.start) begin
      scale_q <= 16'(acsa_pkg::full_scale(req_i.gain));
      p1_q    <= 39'(req_i.sum);
      off_q   <= req_i.offset;
      cnt8_q  <= req_i.count;
    end else if (state_q == acsa_pkg::ST_MUL1) begin
      p1_q    <= prod[38:0];
      scale_q <= req_scale_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == acsa_pkg::ST_IDLE && req_i.start) req_scale_q <= req_i.scale;
  end

  // output saturation
  always_comb begin
    rsp_o.done = (state_q == acsa_pkg::ST_OUT);
    if (res > 56'sd2147483647)       rsp_o.value = 32'sh7fffffff;
    else if (res < -56'sd2147483648) rsp_o.value = 32'sh80000000;
    else                             rsp_o.value = res[31:0];
  end

  a_done_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == acsa_pkg::ST_FIN |=> rsp_o.done)
    else $error("meas: no done after rounding");
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == acsa_pkg::ST_DIV |-> cnt_q <= 6'd53)
    else $error("meas: divide overrun");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> state_q == acsa_pkg::ST_IDLE)
    else $error("meas: start while busy");

endmodule

// ----- rtl/adc_channel_scan_averager.sv -----
// Top level of the converter channel scan averager.
// Depends on acsa_pkg, acsa_if and acsa_meas.
`timescale 1ns / 1ps
// Usage:
//  in_if carries request beats: tick, write status, read result, start scan.
//  out_if carries result beats: config commands, read requests, measurements;
//  last marks the final beat caused by one request (at most two).
//  Config registers sit on the APB port at 8*index (64-bit data).
// Throughput: one request is taken, then the block holds in_if.ready low
//  until all its results have been taken. A request with no result
//  leaves in_if.ready high; one with a command or read beat also waits
//  out output stalls. One that completes an average runs the shared
//  multiplier twice and a 54-step bit-serial divider before the
//  measurement beat is valid.
// Reset: scan stopped, sums cleared, per-channel counts loaded from the
//  reset average counts; a start request begins the scan.
// A stalled receiver holds the current beat; nothing is lost.
module adc_channel_scan_averager (
  input  logic              clk_i,
  input  logic              rst_ni,
  acsa_in_if.sink           in_if,
  acsa_out_if.source        out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [acsa_pkg::AddrW-1:0] paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  // configuration registers
  logic [3:0]  mask_q;
  logic [11:0] mux_q, gain_q, rate_q;
  logic [31:0] avg_q;
  logic [63:0] scale_q, off_q;
  logic [6:0]  dev_q;
  logic [2:0]  ridx;
  logic        wr;

  assign pready = 1'b1;
  assign ridx = paddr[5:3];
  assign wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q  <= 4'd1;
      mux_q   <= '0;
      gain_q  <= '0;
      rate_q  <= '0;
      avg_q   <= 32'h01010101;
      scale_q <= 64'h0100010001000100;
      off_q   <= '0;
      dev_q   <= 7'd72;
    end else if (wr && paddr[2:0] == 3'd0) begin
      unique case (acsa_pkg::reg_e'(ridx))
        acsa_pkg::REG_MASK:   mask_q  <= pwdata[3:0];
        acsa_pkg::REG_MUX:    mux_q   <= pwdata[11:0];
        acsa_pkg::REG_GAIN:   gain_q  <= pwdata[11:0];
        acsa_pkg::REG_RATE:   rate_q  <= pwdata[11:0];
        acsa_pkg::REG_AVG:    avg_q   <= pwdata[31:0];
        acsa_pkg::REG_SCALE:  scale_q <= pwdata;
        acsa_pkg::REG_OFFSET: off_q   <= pwdata;
        acsa_pkg::REG_DEVADR: dev_q   <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (acsa_pkg::reg_e'(ridx))
      acsa_pkg::REG_MASK:   prdata = 64'(mask_q);
      acsa_pkg::REG_MUX:    prdata = 64'(mux_q);
      acsa_pkg::REG_GAIN:   prdata = 64'(gain_q);
      acsa_pkg::REG_RATE:   prdata = 64'(rate_q);
      acsa_pkg::REG_AVG:    prdata = 64'(avg_q);
      acsa_pkg::REG_SCALE:  prdata = scale_q;
      acsa_pkg::REG_OFFSET: prdata = off_q;
      acsa_pkg::REG_DEVADR: prdata = 64'(dev_q);
      default:              prdata = '0;
    endcase
  end

  // scan state
  logic [1:0]         cur_q, cur_d;
  logic [7:0]         ticks_q, ticks_d;
  logic               wfail_q, wfail_d, await_q, await_d, active_q, active_d;
  logic signed [23:0] sums_q [acsa_pkg::NumCh];
  logic [7:0]         left_q [acsa_pkg::NumCh];

  // pending output beats: slot A then slot B
  logic               busy_q;
  logic               a_vld_q, b_vld_q, a_meas_q;
  logic [1:0]         a_kind_q, b_kind_q, a_ch_q, b_ch_q;
  logic               meas_pend_q;

  acsa_pkg::meas_req_t mreq;
  acsa_pkg::meas_rsp_t mrsp;
  logic signed [31:0]  mval_q;

  acsa_meas u_meas (.clk_i, .rst_ni, .req_i(mreq), .rsp_o(mrsp));

  // decode of the accepted request
  logic        acc;
  logic [3:0]  live;
  logic [1:0]  nxt;
  logic [2:0]  cur_rate;
  logic [8:0]  wait_n;
  logic [7:0]  ticks_inc;
  logic        emit_cmd, emit_rd, emit_meas, finish;
  logic signed [23:0] new_sum;
  logic [7:0]  avg_c;

  assign acc = in_if.valid & in_if.ready;
  assign live = mask_q;
  assign cur_rate = rate_q[3*cur_q +: 3];
  assign wait_n = 9'(acsa_pkg::WaitBase >> cur_rate) + 9'd1;
  assign ticks_inc = (ticks_q == 8'd255) ? ticks_q : ticks_q + 8'd1;
  assign new_sum = sums_q[cur_q] + 24'(in_if.sample);
  assign avg_c = avg_q[8*cur_q +: 8];

  // next enabled channel after cur
  always_comb begin
    logic [1:0] c1, c2, c3;
    c1 = cur_q + 2'd1;
    c2 = cur_q + 2'd2;
    c3 = cur_q + 2'd3;
    if (live[c1])      nxt = c1;
    else if (live[c2]) nxt = c2;
    else if (live[c3]) nxt = c3;
    else               nxt = cur_q;
  end

  always_comb begin
    cur_d = cur_q; ticks_d = ticks_q; wfail_d = wfail_q;
    await_d = await_q; active_d = active_q;
    emit_cmd = 1'b0; emit_rd = 1'b0; emit_meas = 1'b0; finish = 1'b0;
    if (acc) begin
      unique case (acsa_pkg::req_e'(in_if.req_type))
        acsa_pkg::REQ_START: begin
          wfail_d = 1'b0; await_d = 1'b0;
          finish = 1'b1;
        end
        acsa_pkg::REQ_STATUS:
          if (active_q && !await_q) wfail_d = in_if.bus_error;
        acsa_pkg::REQ_TICK:
          if (active_q) begin
            if (live == 4'd0) begin
              active_d = 1'b0; await_d = 1'b0;
            end else if (!await_q) begin
              ticks_d = ticks_inc;
              if ({1'b0, ticks_inc} > wait_n) begin
                if (wfail_q) finish = 1'b1;
                else begin
                  emit_rd = 1'b1; await_d = 1'b1;
                end
              end
            end
          end
        acsa_pkg::REQ_READ:
          if (active_q && await_q) begin
            await_d = 1'b0;
            if (!in_if.bus_error && left_q[cur_q] <= 8'd1) emit_meas = 1'b1;
            finish = 1'b1;
          end
        default: ;
      endcase
      // advance to the next channel
      if (finish) begin
        if (live == 4'd0) begin
          active_d = 1'b0; await_d = 1'b0;
        end else begin
          cur_d = nxt; ticks_d = '0; wfail_d = 1'b0; await_d = 1'b0;
          active_d = 1'b1; emit_cmd = 1'b1;
        end
      end
    end
  end

  // measurement request uses pre-clear sum
  always_comb begin
    mreq.start  = emit_meas;
    mreq.sum    = new_sum;
    mreq.gain   = gain_q[3*cur_q +: 3];
    mreq.scale  = scale_q[16*cur_q +: 16];
    mreq.offset = off_q[16*cur_q +: 16];
    mreq.count  = avg_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0; ticks_q <= '0; wfail_q <= 1'b0; await_q <= 1'b0;
      active_q <= 1'b0;
      for (int i = 0; i < acsa_pkg::NumCh; i++) begin
        sums_q[i] <= '0;
        left_q[i] <= 8'd1;
      end
    end else begin
      cur_q <= cur_d; ticks_q <= ticks_d; wfail_q <= wfail_d;
      await_q <= await_d; active_q <= active_d;
      if (acc && in_if.req_type == acsa_pkg::REQ_START) begin
        for (int i = 0; i < acsa_pkg::NumCh; i++) begin
          sums_q[i] <= '0;
          left_q[i] <= (avg_q[8*i +: 8] == 8'd0) ? 8'd1 : avg_q[8*i +: 8];
        end
      end else if (acc && in_if.req_type == acsa_pkg::REQ_READ && active_q && await_q
                   && !in_if.bus_error) begin
        if (left_q[cur_q] > 8'd1) begin
          sums_q[cur_q] <= new_sum;
          left_q[cur_q] <= left_q[cur_q] - 8'd1;
        end else begin
          sums_q[cur_q] <= '0;
          left_q[cur_q] <= (avg_c == 8'd0) ? 8'd1 : avg_c;
        end
      end
    end
  end

  // output slots: A goes first; a measurement waits for the unit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; a_vld_q <= 1'b0; b_vld_q <= 1'b0; a_meas_q <= 1'b0;
      meas_pend_q <= 1'b0;
    end else if (acc) begin
      busy_q <= emit_cmd | emit_rd | emit_meas;
      a_meas_q <= emit_meas;
      meas_pend_q <= emit_meas;
      if (emit_meas) begin
        a_vld_q <= 1'b0; a_kind_q <= acsa_pkg::KIND_MEAS; a_ch_q <= cur_q;
        b_vld_q <= emit_cmd; b_kind_q <= acsa_pkg::KIND_CMD; b_ch_q <= cur_d;
      end else begin
        a_vld_q <= emit_cmd | emit_rd;
        a_kind_q <= emit_rd ? acsa_pkg::KIND_RD : acsa_pkg::KIND_CMD;
        a_ch_q <= emit_rd ? cur_q : cur_d;
        b_vld_q <= 1'b0;
      end
    end else begin
      if (mrsp.done && meas_pend_q) begin
        a_vld_q <= 1'b1; meas_pend_q <= 1'b0;
      end
      if (out_if.valid && out_if.ready) begin
        if (b_vld_q) begin
          a_vld_q <= 1'b1; a_kind_q <= b_kind_q; a_ch_q <= b_ch_q;
          a_meas_q <= 1'b0; b_vld_q <= 1'b0;
        end else begin
          a_vld_q <= 1'b0; busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mrsp.done) mval_q <= mrsp.value;
  end

  assign in_if.ready = !busy_q;
  assign out_if.valid = a_vld_q;
  assign out_if.kind = a_kind_q;
  assign out_if.channel = a_ch_q;
  assign out_if.last = !b_vld_q;
  assign out_if.bus_address = a_meas_q ? 7'd0 : dev_q;
  assign out_if.value = a_meas_q ? mval_q : 32'sd0;
  assign out_if.config_word = (a_kind_q == acsa_pkg::KIND_CMD) ?
      (acsa_pkg::CmdBase | {1'b0, mux_q[3*a_ch_q +: 3], gain_q[3*a_ch_q +: 3], 1'b0,
                            rate_q[3*a_ch_q +: 3], 5'd0}) : 16'd0;

  a_no_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> busy_q)
    else $error("result beat while not busy");
  a_b_after_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_vld_q |-> busy_q)
    else $error("second slot held while idle");
  a_await_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    await_q |-> active_q)
    else $error("read awaited without an active scan");

endmodule
